// ----- design/akct_pkg.sv -----
// ----------------------------------------------------------------------------
// akct_pkg
// Shared types and constants for the aging keyed cache table.
// ----------------------------------------------------------------------------
package akct_pkg;

	localparam int MAX_ENTRIES_DEF = 8;
	localparam int KEY_BITS_DEF = 32;
	localparam int REG_W = 16;
	localparam int IDX_W = 2;

	localparam logic [3:0]  CAPACITY_RST = 4'd5;
	localparam logic [15:0] AGE_LIMIT_RST = 16'd60;
	localparam logic [15:0] SCAN_PERIOD_RST = 16'd60;

	localparam logic [IDX_W-1:0] REG_CAPACITY = 2'd0;
	localparam logic [IDX_W-1:0] REG_AGE_LIMIT = 2'd1;
	localparam logic [IDX_W-1:0] REG_SCAN_PERIOD = 2'd2;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;

	localparam logic [1:0] ANS_PUSH = 2'd0;
	localparam logic [1:0] ANS_POP = 2'd1;
	localparam logic [1:0] ANS_EVICT = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] entry_key;
		logic [31:0] entry_handle;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  answer_kind;
		logic        success;
		logic [31:0] answer_key;
		logic [31:0] answer_handle;
		logic        last_of_run;
	} out_item_t;

endpackage

// ----- design/akct_front.sv -----
// ----------------------------------------------------------------------------
// akct_front
// Input stage: takes items, drops operation 3, queues the rest (two deep).
// ----------------------------------------------------------------------------
module akct_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  akct_pkg::in_item_t in_item,
	output logic              q_valid,
	input  logic              q_ready,
	output akct_pkg::in_item_t q_item
);
	import akct_pkg::*;

	in_item_t mem_q [2];
	logic     wr_q, rd_q;
	logic [1:0] cnt_q;
	logic     push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready && (in_item.operation != OP_RSVD);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rd_q];
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ----- design/akct_back.sv -----
// ----------------------------------------------------------------------------
// akct_back
// Executes queued items on the slot table and emits result transfers.
// ----------------------------------------------------------------------------
module akct_back #(
	parameter int MAX_ENTRIES = akct_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_BITS = akct_pkg::KEY_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  akct_pkg::in_item_t q_item,
	input  logic [3:0]         capacity,
	input  logic [15:0]        age_limit,
	input  logic [15:0]        scan_period,
	output logic               out_valid,
	input  logic               out_ready,
	output akct_pkg::out_item_t out_item
);
	import akct_pkg::*;

	localparam int N = MAX_ENTRIES;
	localparam int SW = (N > 1) ? $clog2(N) : 1;
	localparam int CW = $clog2(N + 1);

	typedef enum logic [1:0] {S_IDLE, S_EVICT, S_SCAN, S_EMIT} state_t;

	state_t state_q;
	logic [N-1:0] used_q, aged_q;
	logic [KEY_BITS-1:0] key_q [N];
	logic [31:0] handle_q [N];
	logic [31:0] stamp_q [N];
	logic [31:0] clock_q;
	logic        running_q;
	logic [15:0] countdown_q;
	in_item_t    cur_q;
	out_item_t   obuf_q;
	logic        ovalid_q;

	logic [KEY_BITS-1:0] kin;
	logic [N-1:0] hit;
	logic [SW-1:0] hit_idx, free_idx, best_idx, pick_idx;
	logic          best_any, pick_any;
	logic [CW-1:0] used_cnt;
	logic [CW-1:0] cap_eff;
	logic [15:0]   per_eff;
	logic          obuf_free;

	assign kin = KEY_BITS'(q_item.entry_key);
	assign per_eff = (scan_period == 16'd0) ? 16'd1 : scan_period;
	assign obuf_free = !ovalid_q || out_ready;
	assign out_valid = ovalid_q;
	assign out_item = obuf_q;

	always_comb begin
		cap_eff = (capacity == 4'd0) ? CW'(1)
			: ((32'(capacity) > N) ? CW'(N) : CW'(capacity));
		hit = '0;
		hit_idx = '0;
		free_idx = '0;
		used_cnt = '0;
		for (int i = N - 1; i >= 0; i--) begin
			hit[i] = used_q[i] && (key_q[i] == kin);
			if (hit[i]) hit_idx = SW'(i);
			if (!used_q[i]) free_idx = SW'(i);
		end
		for (int i = 0; i < N; i++) used_cnt = used_cnt + CW'(used_q[i]);
	end

	// oldest entry: max age, ties to smallest key
	always_comb begin
		logic [31:0] ba;
		logic [31:0] a;
		best_any = 1'b0;
		best_idx = '0;
		ba = '0;
		a = '0;
		for (int i = 0; i < N; i++) begin
			a = clock_q - stamp_q[i];
			if (used_q[i] && (!best_any || a > ba
				|| (a == ba && key_q[i] < key_q[best_idx]))) begin
				best_any = 1'b1;
				best_idx = SW'(i);
				ba = a;
			end
		end
	end

	// smallest aged key
	always_comb begin
		pick_any = 1'b0;
		pick_idx = '0;
		for (int i = 0; i < N; i++) begin
			if (aged_q[i] && (!pick_any || key_q[i] < key_q[pick_idx])) begin
				pick_any = 1'b1;
				pick_idx = SW'(i);
			end
		end
	end

	assign q_ready = (state_q == S_IDLE) && obuf_free;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid && obuf_free && q_item.operation == OP_PUSH
			&& kin != '0 && q_item.entry_handle != '0) begin
			if (|hit) begin
				handle_q[hit_idx] <= q_item.entry_handle;
				stamp_q[hit_idx] <= clock_q;
			end
		end
		if (state_q == S_EMIT && obuf_free) begin
			key_q[free_idx] <= KEY_BITS'(cur_q.entry_key);
			handle_q[free_idx] <= cur_q.entry_handle;
			stamp_q[free_idx] <= clock_q;
		end
		if (q_ready && q_valid) cur_q <= q_item;
		if (state_q == S_IDLE && q_valid && obuf_free) begin
			case (q_item.operation)
				OP_PUSH: begin
					obuf_q <= '{ANS_PUSH, (kin != '0) && (q_item.entry_handle != '0),
						32'(kin), 32'd0, 1'b1};
				end
				OP_POP: begin
					obuf_q <= '{ANS_POP, (kin != '0) && (|hit), 32'(kin),
						((kin != '0) && (|hit)) ? handle_q[hit_idx] : 32'd0, 1'b1};
				end
				default: ;
			endcase
		end else if (state_q == S_EVICT && obuf_free) begin
			obuf_q.answer_kind <= ANS_EVICT;
			obuf_q.success <= 1'b1;
			obuf_q.answer_key <= 32'(key_q[best_idx]);
			obuf_q.answer_handle <= handle_q[best_idx];
			obuf_q.last_of_run <= 1'b0;
		end else if (state_q == S_EMIT && obuf_free) begin
			obuf_q.answer_kind <= ANS_PUSH;
			obuf_q.success <= 1'b1;
			obuf_q.answer_key <= 32'(KEY_BITS'(cur_q.entry_key));
			obuf_q.answer_handle <= 32'd0;
			obuf_q.last_of_run <= 1'b1;
		end else if (state_q == S_SCAN && obuf_free && pick_any) begin
			obuf_q.answer_kind <= ANS_EVICT;
			obuf_q.success <= 1'b1;
			obuf_q.answer_key <= 32'(key_q[pick_idx]);
			obuf_q.answer_handle <= handle_q[pick_idx];
			obuf_q.last_of_run <= ($countones(aged_q) == 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic ov_next;
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			aged_q <= '0;
			clock_q <= '0;
			running_q <= 1'b0;
			countdown_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			ov_next = ovalid_q && !out_ready;
			case (state_q)
				S_IDLE: begin
					if (q_valid && obuf_free) begin
						case (q_item.operation)
							OP_PUSH: begin
								if (kin == '0 || q_item.entry_handle == '0
									|| (|hit)) begin
									ov_next = 1'b1;
								end else begin
									if (used_cnt == '0) begin
										running_q <= 1'b1;
										countdown_q <= per_eff;
									end
									state_q <= (used_cnt >= cap_eff) ? S_EVICT : S_EMIT;
								end
							end
							OP_POP: begin
								ov_next = 1'b1;
								if (kin != '0 && (|hit)) begin
									used_q[hit_idx] <= 1'b0;
									if (used_cnt == CW'(1)) begin
										running_q <= 1'b0;
										countdown_q <= '0;
									end
								end
							end
							OP_TICK: begin
								clock_q <= clock_q + 32'd1;
								if (running_q) begin
									if (countdown_q <= 16'd1) begin
										countdown_q <= per_eff;
										for (int i = 0; i < N; i++)
											aged_q[i] <= used_q[i] && ((clock_q + 32'd1
												- stamp_q[i]) >= 32'(age_limit));
										state_q <= S_SCAN;
									end else begin
										countdown_q <= countdown_q - 16'd1;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_EVICT: begin
					if (obuf_free) begin
						ov_next = best_any;
						if (best_any) used_q[best_idx] <= 1'b0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (obuf_free) begin
						ov_next = 1'b1;
						used_q[free_idx] <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (!pick_any) begin
						if (used_q == '0) begin
							running_q <= 1'b0;
							countdown_q <= '0;
						end
						state_q <= S_IDLE;
					end else if (obuf_free) begin
						ov_next = 1'b1;
						aged_q[pick_idx] <= 1'b0;
						used_q[pick_idx] <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			ovalid_q <= ov_next;
		end
	end
endmodule

// ----- design/aging_keyed_cache_table_top.sv -----
// ----------------------------------------------------------------------------
// aging_keyed_cache_table_top
// Small associative key/handle table with oldest-entry eviction and aging scans.
// ----------------------------------------------------------------------------
// A push or pop is handled in the idle state of the execution unit; a push of a
// new key goes through the emit state to fill a free slot, and first through the
// evict state when the table is full; a tick with a scan due reports aged entries
// one at a time in the scan state. Key match and oldest-entry search compare all
// slots in parallel; one result register paces one result per cycle unless stalled.
module aging_keyed_cache_table_top #(
	parameter int MAX_ENTRIES = akct_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_BITS = akct_pkg::KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  akct_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output akct_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import akct_pkg::*;

	logic [3:0]  capacity_q;
	logic [15:0] age_limit_q, scan_period_q;
	logic        q_valid, q_ready;
	in_item_t    q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RST;
			age_limit_q <= AGE_LIMIT_RST;
			scan_period_q <= SCAN_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAPACITY: capacity_q <= cfg_data[3:0];
				REG_AGE_LIMIT: age_limit_q <= cfg_data;
				REG_SCAN_PERIOD: scan_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	akct_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	akct_back #(.MAX_ENTRIES(MAX_ENTRIES), .KEY_BITS(KEY_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.capacity(capacity_q), .age_limit(age_limit_q), .scan_period(scan_period_q),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);
endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the aging keyed cache table. Push, pop, tick and
// unused operations go in through a valid/ready driver with random gaps. An
// in-bench model of the table predicts every answer and eviction report, and
// the monitor compares each output transfer with the oldest prediction. The
// run steps through several register settings, including the extremes.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import akct_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int SLOTS = 8;
	localparam int SETTLE = 40;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	in_item_t in_item;
	out_item_t out_item;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	aging_keyed_cache_table_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// table model
	logic [3:0] cap_r;
	logic [15:0] age_r, period_r;
	logic slot_on[SLOTS];
	logic [31:0] slot_k[SLOTS], slot_h[SLOTS], slot_t[SLOTS];
	logic [31:0] secs;
	logic scan_on;
	logic [15:0] countdown;

	in_item_t pend_q[$];
	out_item_t answer_q[$];
	logic [31:0] key_pool[10];
	int errors = 0;
	int cycles = 0;
	int rx_count = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	logic held = 0;
	logic in_fired = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int used_count();
		int c;
		c = 0;
		for (int j = 0; j < SLOTS; j++) if (slot_on[j]) c++;
		return c;
	endfunction

	function automatic logic [15:0] period_eff();
		return period_r == 0 ? 16'd1 : period_r;
	endfunction

	task automatic table_step(input in_item_t it);
		out_item_t res[$];
		int idx, best, pick, n, capx;
		logic [31:0] a, best_age;
		logic aged[SLOTS];
		idx = -1;
		for (int j = 0; j < SLOTS; j++)
			if (slot_on[j] && slot_k[j] == it.entry_key) idx = j;
		case (it.operation)
			OP_PUSH: begin
				if (it.entry_key == 0 || it.entry_handle == 0) begin
					res.push_back('{ANS_PUSH, 1'b0, it.entry_key, 32'd0, 1'b0});
				end else if (idx >= 0) begin
					slot_h[idx] = it.entry_handle;
					slot_t[idx] = secs;
					res.push_back('{ANS_PUSH, 1'b1, it.entry_key, 32'd0, 1'b0});
				end else begin
					n = used_count();
					if (n == 0) begin
						scan_on = 1;
						countdown = period_eff();
					end
					capx = cap_r == 0 ? 1 : (cap_r > SLOTS ? SLOTS : cap_r);
					if (n >= capx) begin
						best = -1;
						best_age = 0;
						for (int j = 0; j < SLOTS; j++) begin
							if (!slot_on[j]) continue;
							a = secs - slot_t[j];
							if (best < 0 || a > best_age ||
							    (a == best_age && slot_k[j] < slot_k[best])) begin
								best = j;
								best_age = a;
							end
						end
						if (best >= 0) begin
							res.push_back('{ANS_EVICT, 1'b1, slot_k[best], slot_h[best], 1'b0});
							slot_on[best] = 0;
						end
					end
					for (int j = 0; j < SLOTS; j++) begin
						if (!slot_on[j]) begin
							slot_on[j] = 1;
							slot_k[j] = it.entry_key;
							slot_h[j] = it.entry_handle;
							slot_t[j] = secs;
							break;
						end
					end
					res.push_back('{ANS_PUSH, 1'b1, it.entry_key, 32'd0, 1'b0});
				end
			end
			OP_POP: begin
				if (it.entry_key == 0 || idx < 0) begin
					res.push_back('{ANS_POP, 1'b0, it.entry_key, 32'd0, 1'b0});
				end else begin
					res.push_back('{ANS_POP, 1'b1, it.entry_key, slot_h[idx], 1'b0});
					slot_on[idx] = 0;
					if (used_count() == 0) begin
						scan_on = 0;
						countdown = 0;
					end
				end
			end
			OP_TICK: begin
				secs = secs + 1;
				if (scan_on) begin
					if (countdown <= 1) begin
						countdown = period_eff();
						for (int j = 0; j < SLOTS; j++)
							aged[j] = slot_on[j] && (secs - slot_t[j]) >= {16'd0, age_r};
						forever begin
							pick = -1;
							for (int j = 0; j < SLOTS; j++)
								if (aged[j] && (pick < 0 || slot_k[j] < slot_k[pick])) pick = j;
							if (pick < 0) break;
							aged[pick] = 0;
							res.push_back('{ANS_EVICT, 1'b1, slot_k[pick], slot_h[pick], 1'b0});
							slot_on[pick] = 0;
						end
						if (used_count() == 0) begin
							scan_on = 0;
							countdown = 0;
						end
					end else begin
						countdown = countdown - 1;
					end
				end
			end
			default: ;
		endcase
		if (res.size() > 0) res[res.size()-1].last_of_run = 1'b1;
		foreach (res[i]) answer_q.push_back(res[i]);
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else if (!in_valid || in_fired) begin
			in_fired <= 0;
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 0;
			end else if (pend_q.size() > 0) begin
				in_item <= pend_q.pop_front();
				in_valid <= 1;
				gap_left <= pick_gap();
			end else begin
				in_valid <= 0;
			end
		end
	end

	// receiver: random stalls, one long hold after a while
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 0;
		end else if (!held && rx_count >= 120) begin
			held <= 1;
			hold_left <= 400;
			out_ready <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 0;
		end else begin
			out_ready <= 1;
			if (cycles[9:8] != 2'b00 && $urandom_range(0, 3) == 0)
				stall_left <= pick_gap();
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t e;
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
		if (arst_n && in_valid && in_ready) begin
			in_fired <= 1;
			table_step(in_item);
		end
		if (arst_n && out_valid && out_ready) begin
			rx_count <= rx_count + 1;
			if (answer_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %p", $time, out_item);
			end else begin
				e = answer_q.pop_front();
				if (e.answer_kind != out_item.answer_kind) begin
					errors++;
					$display("%0t: answer_kind exp %0d got %0d", $time, e.answer_kind,
						out_item.answer_kind);
				end
				if (e.success != out_item.success) begin
					errors++;
					$display("%0t: success exp %0d got %0d", $time, e.success, out_item.success);
				end
				if (e.answer_key != out_item.answer_key) begin
					errors++;
					$display("%0t: answer_key exp %h got %h", $time, e.answer_key,
						out_item.answer_key);
				end
				if (e.answer_handle != out_item.answer_handle) begin
					errors++;
					$display("%0t: answer_handle exp %h got %h", $time, e.answer_handle,
						out_item.answer_handle);
				end
				if (e.last_of_run != out_item.last_of_run) begin
					errors++;
					$display("%0t: last_of_run exp %0d got %0d", $time, e.last_of_run,
						out_item.last_of_run);
				end
			end
		end
	end

	task automatic add(input logic [1:0] op, input logic [31:0] k, input logic [31:0] h);
		pend_q.push_back('{op, k, h});
	endtask

	task automatic drain();
		while (pend_q.size() > 0 || in_valid || answer_q.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			REG_CAPACITY: cap_r = val[3:0];
			REG_AGE_LIMIT: age_r = val;
			default: period_r = val;
		endcase
	endtask

	task automatic random_items(input int count);
		int r;
		logic [31:0] k, h;
		for (int j = 0; j < 10; j++)
			key_pool[j] = ($urandom_range(0, 1)) ? $urandom : $urandom_range(1, 20);
		for (int j = 0; j < count; j++) begin
			r = $urandom_range(0, 99);
			k = ($urandom_range(0, 19) == 0) ? ($urandom_range(0, 1) ? 32'd0 : $urandom)
				: key_pool[$urandom_range(0, 9)];
			h = ($urandom_range(0, 24) == 0) ? 32'd0 : $urandom;
			if (r < 42) add(OP_PUSH, k, h);
			else if (r < 64) add(OP_POP, k, $urandom);
			else if (r < 96) add(OP_TICK, $urandom, $urandom);
			else add(OP_NONE, $urandom, $urandom);
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_item = '0;
		out_ready = 0;
		cfg_we = 0;
		cfg_index = REG_CAPACITY;
		cfg_data = '0;
		cap_r = CAPACITY_RST;
		age_r = AGE_LIMIT_RST;
		period_r = SCAN_PERIOD_RST;
		for (int j = 0; j < SLOTS; j++) slot_on[j] = 0;
		secs = 0;
		scan_on = 0;
		countdown = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: refusals, misses, fill and evict, refresh, extremes
		add(OP_PUSH, 32'd0, 32'd5);
		add(OP_PUSH, 32'd7, 32'd0);
		add(OP_POP, 32'd0, 32'd0);
		add(OP_POP, 32'd99, 32'd0);
		add(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add(OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add(OP_PUSH, 32'd3, 32'd30);
		add(OP_TICK, 32'd0, 32'd0);
		add(OP_PUSH, 32'd2, 32'd20);
		add(OP_PUSH, 32'd1, 32'd10);
		add(OP_PUSH, 32'd4, 32'd40);
		add(OP_PUSH, 32'hFFFF_FFFF, 32'h1234_5678);
		add(OP_PUSH, 32'd6, 32'd60);
		add(OP_PUSH, 32'd8, 32'd80);
		add(OP_POP, 32'd2, 32'd0);
		add(OP_POP, 32'd2, 32'd0);
		add(OP_POP, 32'hFFFF_FFFF, 32'd0);
		drain();

		write_reg(REG_CAPACITY, 16'd2);
		write_reg(REG_AGE_LIMIT, 16'd0);
		write_reg(REG_SCAN_PERIOD, 16'd0);
		add(OP_PUSH, 32'd9, 32'd1);
		add(OP_TICK, 32'd0, 32'd0);
		add(OP_PUSH, 32'd5, 32'd2);
		add(OP_TICK, 32'd0, 32'd0);
		drain();

		random_items(50);
		drain();
		write_reg(REG_CAPACITY, 16'd1);
		write_reg(REG_AGE_LIMIT, 16'd1);
		write_reg(REG_SCAN_PERIOD, 16'd1);
		random_items(60);
		drain();
		write_reg(REG_CAPACITY, 16'd8);
		write_reg(REG_AGE_LIMIT, 16'd4);
		write_reg(REG_SCAN_PERIOD, 16'd3);
		random_items(90);
		drain();
		write_reg(REG_CAPACITY, 16'd15);
		write_reg(REG_AGE_LIMIT, 16'hFFFF);
		write_reg(REG_SCAN_PERIOD, 16'hFFFF);
		random_items(50);
		drain();
		write_reg(REG_CAPACITY, 16'd0);
		write_reg(REG_AGE_LIMIT, 16'd3);
		write_reg(REG_SCAN_PERIOD, 16'd2);
		random_items(60);
		drain();
		write_reg(REG_CAPACITY, 16'd3);
		write_reg(REG_AGE_LIMIT, 16'd8);
		write_reg(REG_SCAN_PERIOD, 16'd5);
		random_items(80);
		drain();

		if (errors == 0 && answer_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
